@@ rtl/dsad_pkg.sv @@
// Package for the data-space address decoder.
// Holds the item structs, code constants, reset values and the command struct.
// No dependencies.
`default_nettype none

package dsad_pkg;

    // Input item as one packed word.
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  write_byte;
        logic [15:0] window_length;
        logic [3:0]  window_device;
    } in_item_t;

    // Result item as one packed word.
    typedef struct packed {
        logic [7:0]  read_byte;
        logic [3:0]  target;
        logic [3:0]  device_id;
        logic [15:0] device_offset;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
    } ctrl_cmd_t;

    // Item modes.
    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_APPEND = 2'd2;

    // Target codes.
    localparam logic [3:0] TGT_SRAM     = 4'd0;
    localparam logic [3:0] TGT_REG      = 4'd1;
    localparam logic [3:0] TGT_STATUS   = 4'd2;
    localparam logic [3:0] TGT_SPL      = 4'd3;
    localparam logic [3:0] TGT_SPH      = 4'd4;
    localparam logic [3:0] TGT_PERIPH   = 4'd5;
    localparam logic [3:0] TGT_UNMAPPED = 4'd6;
    localparam logic [3:0] TGT_MAPPED   = 4'd7;
    localparam logic [3:0] TGT_FULL     = 4'd8;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [2:0] CFG_SRAM_START     = 3'd0;
    localparam logic [2:0] CFG_SRAM_LENGTH    = 3'd1;
    localparam logic [2:0] CFG_REGFILE_START  = 3'd2;
    localparam logic [2:0] CFG_REGFILE_LENGTH = 3'd3;
    localparam logic [2:0] CFG_STATUS_ADDR    = 3'd4;
    localparam logic [2:0] CFG_STACK_LOW      = 3'd5;
    localparam logic [2:0] CFG_STACK_HIGH     = 3'd6;

    // Configuration reset values.
    localparam logic [15:0] RST_SRAM_START     = 16'd256;
    localparam logic [11:0] RST_SRAM_LENGTH    = 12'd2048;
    localparam logic [15:0] RST_REGFILE_START  = 16'd0;
    localparam logic [5:0]  RST_REGFILE_LENGTH = 6'd32;
    localparam logic [15:0] RST_STATUS_ADDR    = 16'd95;
    localparam logic [15:0] RST_STACK_LOW      = 16'd93;
    localparam logic [15:0] RST_STACK_HIGH     = 16'd94;

    // Fixed byte patterns.
    localparam logic [7:0]  BYTE_ONES  = 8'hFF;
    localparam logic [15:0] HIGH_MASK  = 16'hFF00;
    localparam logic [15:0] LOW_MASK   = 16'h00FF;

endpackage

`default_nettype wire

@@ rtl/dsad_ctrl.sv @@
// Controller state machine of the data-space address decoder.
// Sequences capture, execute and output load; depends on dsad_pkg.
`default_nettype none

module dsad_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output dsad_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   load;
    logic   accept;

    // The output register takes a result when it is empty or being drained.
    assign load     = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);
    assign in_stall = !((state_reg == ST_IDLE) || load);
    assign accept   = in_valid && !in_stall;

    // Next state and output valid.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (load)
                begin
                    state_next = accept ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cmd.capture  = accept;
    assign cmd.execute  = (state_reg == ST_EXEC);
    assign cmd.load_out = load;

endmodule

`default_nettype wire

@@ rtl/dsad_datapath.sv @@
// Datapath of the data-space address decoder: configuration, SRAM, register
// file, status, stack pointer, peripheral windows and the output register.
// Depends on dsad_pkg.
`default_nettype none

module dsad_datapath #(
    parameter int SRAM_BYTES     = 2048,
    parameter int WINDOW_SLOTS   = 8,
    parameter int REGISTER_COUNT = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire dsad_pkg::ctrl_cmd_t                  cmd,
    input  wire dsad_pkg::in_item_t                   in_item,
    input  wire logic                                 cfg_write_en,
    input  wire logic [dsad_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [dsad_pkg::CFG_DATA_W-1:0]      cfg_data,
    output dsad_pkg::out_item_t                       out_item
);

    localparam int SIDX_W = $clog2(SRAM_BYTES);
    localparam int RIDX_W = $clog2(REGISTER_COUNT);
    localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);

    // Configuration registers.
    logic [15:0] sram_start_reg;
    logic [11:0] sram_length_reg;
    logic [15:0] regfile_start_reg;
    logic [5:0]  regfile_length_reg;
    logic [15:0] status_addr_reg;
    logic [15:0] stack_low_reg;
    logic [15:0] stack_high_reg;

    // Architectural state.
    logic [7:0]  sram_mem [SRAM_BYTES];
    logic [7:0]  regfile_reg [REGISTER_COUNT];
    logic [7:0]  status_reg;
    logic [15:0] sp_reg;
    logic [15:0] win_base_reg [WINDOW_SLOTS];
    logic [15:0] win_size_reg [WINDOW_SLOTS];
    logic [3:0]  win_owner_reg [WINDOW_SLOTS];
    logic [CNT_W-1:0] win_count_reg;

    // Captured item and per-item results.
    dsad_pkg::in_item_t  item_reg;
    logic [7:0]          sram_q_reg;
    logic                res_sram_rd_reg;
    logic [7:0]          res_rd_reg;
    logic [3:0]          res_tgt_reg;
    logic [3:0]          res_dev_reg;
    logic [15:0]         res_off_reg;
    dsad_pkg::out_item_t out_item_reg;

    // Decode signals.
    logic [16:0]       sram_lim;
    logic [16:0]       sram_len_ext;
    logic [16:0]       sram_len;
    logic [17:0]       sram_end;
    logic [5:0]        reg_lim;
    logic [5:0]        reg_len;
    logic [16:0]       reg_end;
    logic              sram_hit;
    logic              reg_hit;
    logic              stat_hit;
    logic              spl_hit;
    logic              sph_hit;
    logic [15:0]       sram_diff;
    logic [15:0]       reg_diff;
    logic [SIDX_W-1:0] sram_idx;
    logic [RIDX_W-1:0] reg_idx;
    logic [WINDOW_SLOTS-1:0] win_hit;
    logic              per_hit;
    logic [3:0]        per_dev;
    logic [15:0]       per_off;
    logic              is_access;
    logic              is_wr;
    logic              is_append;
    logic              table_full;
    logic [3:0]        dec_tgt;
    logic [7:0]        dec_rd;

    // SRAM and register windows, with lengths clamped to what is built.
    assign sram_lim     = 17'(SRAM_BYTES);
    assign sram_len_ext = {5'd0, sram_length_reg};
    assign sram_len     = (sram_len_ext < sram_lim) ? sram_len_ext : sram_lim;
    assign sram_end     = {2'd0, sram_start_reg} + {1'b0, sram_len};
    assign sram_hit     = (item_reg.address >= sram_start_reg)
                          && ({2'd0, item_reg.address} < sram_end);
    assign sram_diff    = item_reg.address - sram_start_reg;
    assign sram_idx     = sram_diff[SIDX_W-1:0];

    assign reg_lim  = 6'(REGISTER_COUNT);
    assign reg_len  = (regfile_length_reg < reg_lim) ? regfile_length_reg : reg_lim;
    assign reg_end  = {1'b0, regfile_start_reg} + {11'd0, reg_len};
    assign reg_hit  = (item_reg.address >= regfile_start_reg)
                      && ({1'b0, item_reg.address} < reg_end);
    assign reg_diff = item_reg.address - regfile_start_reg;
    assign reg_idx  = reg_diff[RIDX_W-1:0];

    // Single-address registers; the high stack byte is absent at address zero.
    assign stat_hit = (item_reg.address == status_addr_reg);
    assign spl_hit  = (item_reg.address == stack_low_reg);
    assign sph_hit  = (stack_high_reg != 16'd0) && (item_reg.address == stack_high_reg);

    // Peripheral windows compare in parallel; ends do not wrap past 0xFFFF.
    always_comb
    begin
        for (int i = 0; i < WINDOW_SLOTS; i++)
        begin
            win_hit[i] = (CNT_W'(i) < win_count_reg)
                         && (item_reg.address >= win_base_reg[i])
                         && ({1'b0, item_reg.address}
                             < ({1'b0, win_base_reg[i]} + {1'b0, win_size_reg[i]}));
        end
    end

    // The earliest appended window that matches wins.
    always_comb
    begin
        per_hit = 1'b0;
        per_dev = 4'd0;
        per_off = 16'd0;
        for (int i = WINDOW_SLOTS - 1; i >= 0; i--)
        begin
            if (win_hit[i])
            begin
                per_hit = 1'b1;
                per_dev = win_owner_reg[i];
                per_off = item_reg.address - win_base_reg[i];
            end
        end
    end

    assign is_access  = (item_reg.mode == dsad_pkg::MODE_READ)
                        || (item_reg.mode == dsad_pkg::MODE_WRITE);
    assign is_wr      = (item_reg.mode == dsad_pkg::MODE_WRITE);
    assign is_append  = (item_reg.mode == dsad_pkg::MODE_APPEND);
    assign table_full = (win_count_reg >= CNT_W'(WINDOW_SLOTS));

    // Priority decode of the target and the read byte for non-SRAM targets.
    always_comb
    begin
        dec_tgt = dsad_pkg::TGT_UNMAPPED;
        dec_rd  = 8'd0;
        case (item_reg.mode)
            dsad_pkg::MODE_APPEND:
            begin
                dec_tgt = table_full ? dsad_pkg::TGT_FULL : dsad_pkg::TGT_MAPPED;
            end
            dsad_pkg::MODE_READ, dsad_pkg::MODE_WRITE:
            begin
                if (sram_hit)
                begin
                    dec_tgt = dsad_pkg::TGT_SRAM;
                end
                else if (reg_hit)
                begin
                    dec_tgt = dsad_pkg::TGT_REG;
                    dec_rd  = regfile_reg[reg_idx];
                end
                else if (stat_hit)
                begin
                    dec_tgt = dsad_pkg::TGT_STATUS;
                    dec_rd  = status_reg;
                end
                else if (spl_hit)
                begin
                    dec_tgt = dsad_pkg::TGT_SPL;
                    dec_rd  = sp_reg[7:0];
                end
                else if (sph_hit)
                begin
                    dec_tgt = dsad_pkg::TGT_SPH;
                    dec_rd  = sp_reg[15:8];
                end
                else if (per_hit)
                begin
                    dec_tgt = dsad_pkg::TGT_PERIPH;
                end
                else
                begin
                    dec_rd = dsad_pkg::BYTE_ONES;
                end
                if (is_wr)
                begin
                    dec_rd = 8'd0;
                end
            end
            default:
            begin
                dec_tgt = dsad_pkg::TGT_UNMAPPED;
            end
        endcase
    end

    // Configuration, register file, status, stack pointer and window count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sram_start_reg     <= dsad_pkg::RST_SRAM_START;
            sram_length_reg    <= dsad_pkg::RST_SRAM_LENGTH;
            regfile_start_reg  <= dsad_pkg::RST_REGFILE_START;
            regfile_length_reg <= dsad_pkg::RST_REGFILE_LENGTH;
            status_addr_reg    <= dsad_pkg::RST_STATUS_ADDR;
            stack_low_reg      <= dsad_pkg::RST_STACK_LOW;
            stack_high_reg     <= dsad_pkg::RST_STACK_HIGH;
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                regfile_reg[i] <= 8'd0;
            end
            status_reg    <= 8'd0;
            sp_reg        <= 16'd0;
            win_count_reg <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    dsad_pkg::CFG_SRAM_START:     sram_start_reg     <= cfg_data;
                    dsad_pkg::CFG_SRAM_LENGTH:    sram_length_reg    <= cfg_data[11:0];
                    dsad_pkg::CFG_REGFILE_START:  regfile_start_reg  <= cfg_data;
                    dsad_pkg::CFG_REGFILE_LENGTH: regfile_length_reg <= cfg_data[5:0];
                    dsad_pkg::CFG_STATUS_ADDR:    status_addr_reg    <= cfg_data;
                    dsad_pkg::CFG_STACK_LOW:      stack_low_reg      <= cfg_data;
                    dsad_pkg::CFG_STACK_HIGH:     stack_high_reg     <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.execute && is_wr)
            begin
                if (dec_tgt == dsad_pkg::TGT_REG)
                begin
                    regfile_reg[reg_idx] <= item_reg.write_byte;
                end
                if (dec_tgt == dsad_pkg::TGT_STATUS)
                begin
                    status_reg <= item_reg.write_byte;
                end
                if (dec_tgt == dsad_pkg::TGT_SPL)
                begin
                    sp_reg <= (sp_reg & dsad_pkg::HIGH_MASK) | {8'd0, item_reg.write_byte};
                end
                if (dec_tgt == dsad_pkg::TGT_SPH)
                begin
                    sp_reg <= (sp_reg & dsad_pkg::LOW_MASK) | {item_reg.write_byte, 8'd0};
                end
            end

            if (cmd.execute && is_append && !table_full)
            begin
                win_count_reg <= win_count_reg + CNT_W'(1);
            end
        end
    end

    // Window slots, filled in order; the count marks which are valid.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WINDOW_SLOTS; i++)
        begin
            if (cmd.execute && is_append && (win_count_reg == CNT_W'(i)))
            begin
                win_base_reg[i]  <= item_reg.address;
                win_size_reg[i]  <= item_reg.window_length;
                win_owner_reg[i] <= item_reg.window_device;
            end
        end
    end

    // SRAM: one synchronous port, read data registered.
    always_ff @(posedge clk)
    begin
        if (cmd.execute && is_access && (dec_tgt == dsad_pkg::TGT_SRAM))
        begin
            if (is_wr)
            begin
                sram_mem[sram_idx] <= item_reg.write_byte;
            end
            else
            begin
                sram_q_reg <= sram_mem[sram_idx];
            end
        end
    end

    // Item capture, per-item results and the output register.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
        if (cmd.execute)
        begin
            res_sram_rd_reg <= (dec_tgt == dsad_pkg::TGT_SRAM) && !is_wr;
            res_rd_reg      <= dec_rd;
            res_tgt_reg     <= dec_tgt;
            res_dev_reg     <= (dec_tgt == dsad_pkg::TGT_PERIPH) ? per_dev : 4'd0;
            res_off_reg     <= (dec_tgt == dsad_pkg::TGT_PERIPH) ? per_off : 16'd0;
        end
        if (cmd.load_out)
        begin
            out_item_reg.read_byte     <= res_sram_rd_reg ? sram_q_reg : res_rd_reg;
            out_item_reg.target        <= res_tgt_reg;
            out_item_reg.device_id     <= res_dev_reg;
            out_item_reg.device_offset <= res_off_reg;
        end
    end

    assign out_item = out_item_reg;

endmodule

`default_nettype wire

@@ rtl/data_space_address_decoder_top.sv @@
// Top level of the data-space address decoder.
// Instantiates dsad_ctrl and dsad_datapath; depends on dsad_pkg.
//
// Usage: an item (read, write or window append) is a transfer on the input
// channel when in_valid is high and in_stall is low. Each item gives exactly
// one result, a transfer on the output channel when out_valid is high and
// out_stall is low. Configuration registers are written through cfg_write_en,
// cfg_index and cfg_data while no item is in flight.
// Sequence: the input transfer captures the item; the execute state then
// decodes the address and performs the access, including the single-port SRAM
// read or write; the finish state then loads the output register once it is
// empty or being drained. One item is in work at a time, so the block takes no
// new item before the last one is done, and the next item is taken in the
// cycle its predecessor moves to the output register.
// Stall: while out_stall holds a result, the finished next result waits and
// the input channel stalls; the output payload stays unchanged.
// Reset: configuration returns to its defaults, the register file, status
// register, stack pointer and window table count clear at once; SRAM contents
// stay undefined until written and need no clearing pass.
`default_nettype none

module data_space_address_decoder_top #(
    parameter int SRAM_BYTES     = 2048,
    parameter int WINDOW_SLOTS   = 8,
    parameter int REGISTER_COUNT = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire dsad_pkg::in_item_t                in_item,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output dsad_pkg::out_item_t                    out_item,
    input  wire logic                              cfg_write_en,
    input  wire logic [dsad_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [dsad_pkg::CFG_DATA_W-1:0]   cfg_data
);

    dsad_pkg::ctrl_cmd_t cmd;

    // Sequencing.
    dsad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Decode, storage and output register.
    dsad_datapath #(
        .SRAM_BYTES     (SRAM_BYTES),
        .WINDOW_SLOTS   (WINDOW_SLOTS),
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_item      (in_item),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_item     (out_item)
    );

`ifndef SYNTHESIS
    // One item in work at a time: a transfer is never followed by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input transfer in two consecutive cycles");

    // The execute step only follows a captured item.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> $past(cmd.capture))
        else $error("execute step without a captured item");

    // A loaded result is presented on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("loaded result not presented");

    // Result targets stay within the defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.target <= dsad_pkg::TGT_FULL))
        else $error("result target out of range");
`endif

endmodule

`default_nettype wire
